// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the sorted priority queue
package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 16;
   localparam int RANK_W       = 8;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int FILL_W       = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              insert;
      logic              pop;
      logic [VALUE_W-1:0] value;
      logic [RANK_W-1:0]  rank;
   } cell_ctrl_type;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module spq_cell (
   input  logic                         clock,
   input  spq_pkg::cell_ctrl_type       ctrl,
   input  logic                         occupied,
   input  logic                         left_gt,
   input  logic [spq_pkg::VALUE_W-1:0]  left_value,
   input  logic [spq_pkg::RANK_W-1:0]   left_rank,
   input  logic [spq_pkg::VALUE_W-1:0]  right_value,
   input  logic [spq_pkg::RANK_W-1:0]   right_rank,
   output logic                         gt,
   output logic [spq_pkg::VALUE_W-1:0]  value,
   output logic [spq_pkg::RANK_W-1:0]   rank
);

   logic [spq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [spq_pkg::RANK_W-1:0]  rank_ff, rank_in;

   // held entry ranks strictly after the incoming one
   assign gt = occupied && (rank_ff > ctrl.rank);

   always_comb begin
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctrl.insert) begin
         if (gt || !occupied) begin
            if (left_gt) begin
               value_in = left_value;
               rank_in  = left_rank;
            end else begin
               value_in = ctrl.value;
               rank_in  = ctrl.rank;
            end
         end
      end else if (ctrl.pop) begin
         value_in = right_value;
         rank_in  = right_rank;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign value = value_ff;
   assign rank  = rank_ff;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// sorted priority queue: top level with the cell chain and result register
//
// req_ channel carries one operation word: insert, pop head, peek head or
// no-op. rsp_ channel returns exactly one result word per operation with
// a status, the head entry for pop and peek, and the fill count after the
// operation. Entries are held in rank order in a row of CAPACITY cells;
// an insert makes every cell compare its rank with the new one and shift
// right by one where needed, a pop shifts the row left by one, so no
// operation has to walk the row, whatever the fill level.
// rsp_valid rises in the cycle after an accepted req_ word; one word
// is taken per cycle while the result side keeps up. The result sits in
// an output register; req_stall rises only while that register is full
// and rsp_stall is high, so a stalled result holds steady and the queue
// waits. Reset (synchronous, active high) empties the queue and drops any
// pending result; cell contents are not cleared, as only occupied cells
// are ever read.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [spq_pkg::OP_W-1:0]       req_operation,
   input  logic [spq_pkg::VALUE_W-1:0]    req_item_value,
   input  logic [spq_pkg::RANK_W-1:0]     req_item_rank,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spq_pkg::VALUE_W-1:0]    rsp_head_value,
   output logic [spq_pkg::RANK_W-1:0]     rsp_head_rank,
   output logic [spq_pkg::FILL_W-1:0]     rsp_fill_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic                        req_accept;
   spq_pkg::op_type             op;
   logic                        is_empty, is_full;
   spq_pkg::cell_ctrl_type      ctrl;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [spq_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [spq_pkg::RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [spq_pkg::FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic [CAPACITY-1:0]         cell_gt;
   logic [CAPACITY-1:0]         cell_occ;
   logic [spq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic [spq_pkg::RANK_W-1:0]  cell_rank  [CAPACITY];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign op         = spq_pkg::op_type'(req_operation);
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == FULL_COUNT);

   always_comb begin
      ctrl.insert = req_accept && (op == spq_pkg::OP_INSERT) && !is_full;
      ctrl.pop    = req_accept && (op == spq_pkg::OP_POP) && !is_empty;
      ctrl.value  = req_item_value;
      ctrl.rank   = req_item_rank;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
         logic                        l_gt;
         logic [spq_pkg::VALUE_W-1:0] l_value, r_value;
         logic [spq_pkg::RANK_W-1:0]  l_rank, r_rank;

         assign cell_occ[gi] = (IDX < count_ff);

         if (gi == 0) begin : g_first
            assign l_gt    = 1'b0;
            assign l_value = req_item_value;
            assign l_rank  = req_item_rank;
         end else begin : g_mid
            assign l_gt    = cell_gt[gi-1];
            assign l_value = cell_value[gi-1];
            assign l_rank  = cell_rank[gi-1];
         end

         // last cell falls out of use on a pop, so it just holds
         if (gi == CAPACITY - 1) begin : g_last
            assign r_value = cell_value[gi];
            assign r_rank  = cell_rank[gi];
         end else begin : g_inner
            assign r_value = cell_value[gi+1];
            assign r_rank  = cell_rank[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (cell_occ[gi]),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .left_rank   (l_rank),
            .right_value (r_value),
            .right_rank  (r_rank),
            .gt          (cell_gt[gi]),
            .value       (cell_value[gi]),
            .rank        (cell_rank[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_status_in = spq_pkg::ST_OK;
      rsp_value_in  = '0;
      rsp_rank_in   = '0;
      case (op)
         spq_pkg::OP_INSERT: begin
            if (is_full) rsp_status_in = spq_pkg::ST_FULL;
         end
         spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
            if (is_empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_value_in = cell_value[0];
               rsp_rank_in  = cell_rank[0];
            end
         end
         default: begin
            rsp_status_in = spq_pkg::ST_OK;
         end
      endcase
      rsp_fill_in = spq_pkg::FILL_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_rank_ff   <= rsp_rank_in;
         rsp_fill_ff   <= rsp_fill_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_value = rsp_value_ff;
   assign rsp_head_rank  = rsp_rank_ff;
   assign rsp_fill_count = rsp_fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("occupancy above capacity");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_accept && (op == spq_pkg::OP_INSERT) && is_full
      |=> (count_ff == $past(count_ff)) && (rsp_status == spq_pkg::ST_FULL))
      else $error("insert into full queue changed occupancy");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      req_accept && (op == spq_pkg::OP_POP) && is_empty
      |=> (rsp_status == spq_pkg::ST_EMPTY) && (rsp_head_value == '0) && is_empty)
      else $error("pop on empty queue misreported");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow occupancy");

endmodule
